### rtl/fcgi_pkg.sv
// Shared types and constants for the FastCGI record deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package fcgi_pkg;

    // Fixed header length, also the required begin-request body length
    localparam int unsigned HDR_LEN = 8;

    // First length byte with this bit set starts a four-byte length
    localparam int unsigned LONG_LEN_BIT = 7;

    // Record types
    localparam logic [7:0] TYPE_BEGIN  = 8'd1;
    localparam logic [7:0] TYPE_ABORT  = 8'd2;
    localparam logic [7:0] TYPE_PARAMS = 8'd4;
    localparam logic [7:0] TYPE_STDIN  = 8'd5;
    localparam logic [7:0] TYPE_DATA   = 8'd8;
    localparam logic [7:0] TYPE_GV     = 8'd9;
    localparam logic [7:0] TYPE_GVR    = 8'd10;

    // Begin-request body byte positions
    localparam logic [15:0] BEGIN_ROLE_HI = 16'd0;
    localparam logic [15:0] BEGIN_ROLE_LO = 16'd1;
    localparam logic [15:0] BEGIN_FLAGS   = 16'd2;

    // Header byte positions
    localparam logic [2:0] HDR_VERSION = 3'd0;
    localparam logic [2:0] HDR_TYPE    = 3'd1;
    localparam logic [2:0] HDR_ID_HI   = 3'd2;
    localparam logic [2:0] HDR_ID_LO   = 3'd3;
    localparam logic [2:0] HDR_LEN_HI  = 3'd4;
    localparam logic [2:0] HDR_LEN_LO  = 3'd5;
    localparam logic [2:0] HDR_PAD     = 3'd6;
    localparam logic [2:0] HDR_LAST    = 3'(HDR_LEN - 1);

    typedef enum logic [3:0] {
        KIND_HEADER    = 4'd0,
        KIND_BEGIN     = 4'd1,
        KIND_STREAM    = 4'd2,
        KIND_NAME_LEN  = 4'd3,
        KIND_VALUE_LEN = 4'd4,
        KIND_NAME      = 4'd5,
        KIND_VALUE     = 4'd6,
        KIND_PADDING   = 4'd7,
        KIND_DISCARD   = 4'd8
    } fcgi_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_VERSION     = 3'd1,
        ERR_TYPE        = 3'd2,
        ERR_REQUEST_ID  = 3'd3,
        ERR_BODY_LENGTH = 3'd4,
        ERR_PAIR_OVERRUN = 3'd5
    } fcgi_err_t;

    // One labeled byte
    typedef struct packed {
        fcgi_kind_t  kind;
        logic [7:0]  data;
        logic [7:0]  rec_type;
        logic [15:0] req_id;
        logic [30:0] pair_len;
        logic [15:0] role;
        logic [7:0]  flags;
        logic        dropped;
        logic        last;
        fcgi_err_t   err;
    } fcgi_result_t;

    localparam int unsigned TDATA_W = 96;
    localparam int unsigned TUSER_W = 5;

endpackage

`default_nettype wire

### rtl/fcgi_parse.sv
// Record parser: header, body and name-value pair state, one byte per advance.
// Depends on fcgi_pkg.
`default_nettype none

module fcgi_parse
    import fcgi_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [7:0]   expected_version,
    input  wire logic [7:0]   byte_in,
    input  wire logic         advance,
    output fcgi_result_t      result
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_CONTENT,
        PH_PADDING
    } phase_t;

    typedef enum logic [1:0] {
        PP_NAME_LEN,
        PP_VALUE_LEN,
        PP_NAME,
        PP_VALUE
    } pair_phase_t;

    phase_t      phase_reg, phase_next;
    pair_phase_t pair_phase_reg, pair_phase_next;
    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]  rec_ver_reg, rec_ver_next;
    logic [7:0]  rec_type_reg, rec_type_next;
    logic [15:0] rec_id_reg, rec_id_next;
    logic [15:0] content_len_reg, content_len_next;
    logic [7:0]  pad_len_reg, pad_len_next;
    logic [15:0] content_cnt_reg, content_cnt_next;
    logic [7:0]  pad_cnt_reg, pad_cnt_next;
    logic [30:0] len_accum_reg, len_accum_next;
    logic [1:0]  len_left_reg, len_left_next;
    logic [30:0] name_len_reg, name_len_next;
    logic [30:0] value_len_reg, value_len_next;
    logic [30:0] pair_left_reg, pair_left_next;
    logic [15:0] role_reg, role_next;
    logic [7:0]  flags_reg, flags_next;
    fcgi_err_t   err_reg, err_next;

    always_comb
    begin
        logic        is_gv;
        logic        is_pair;
        logic        len_done;
        logic [30:0] len_val;
        logic [31:0] need;
        logic [15:0] remaining;
        logic [30:0] left_dec;
        fcgi_kind_t  kind;
        logic [30:0] plen;
        logic        dropped;
        logic        last;
        fcgi_err_t   hdr_err;

        phase_next       = phase_reg;
        pair_phase_next  = pair_phase_reg;
        hdr_idx_next     = hdr_idx_reg;
        rec_ver_next     = rec_ver_reg;
        rec_type_next    = rec_type_reg;
        rec_id_next      = rec_id_reg;
        content_len_next = content_len_reg;
        pad_len_next     = pad_len_reg;
        content_cnt_next = content_cnt_reg;
        pad_cnt_next     = pad_cnt_reg;
        len_accum_next   = len_accum_reg;
        len_left_next    = len_left_reg;
        name_len_next    = name_len_reg;
        value_len_next   = value_len_reg;
        pair_left_next   = pair_left_reg;
        role_next        = role_reg;
        flags_next       = flags_reg;
        err_next         = err_reg;

        is_gv     = rec_type_reg inside {TYPE_GV, TYPE_GVR};
        is_pair   = rec_type_reg inside {TYPE_PARAMS, TYPE_GV, TYPE_GVR};
        len_done  = 1'b0;
        len_val   = '0;
        need      = '0;
        remaining = '0;
        left_dec  = '0;
        kind      = KIND_DISCARD;
        plen      = '0;
        dropped   = 1'b0;
        last      = 1'b0;
        hdr_err   = ERR_NONE;

        if (err_reg == ERR_NONE) begin
            case (phase_reg)
                PH_CONTENT:
                begin
                    content_cnt_next = content_cnt_reg + 16'd1;
                    remaining = content_len_reg - content_cnt_next;
                    if (rec_type_reg == TYPE_BEGIN) begin
                        kind = KIND_BEGIN;
                        if (content_cnt_reg == BEGIN_ROLE_HI)
                            role_next = {byte_in, role_reg[7:0]};
                        else if (content_cnt_reg == BEGIN_ROLE_LO)
                            role_next = {role_reg[15:8], byte_in};
                        else if (content_cnt_reg == BEGIN_FLAGS)
                            flags_next = byte_in;
                    end
                    else if (is_pair) begin
                        case (pair_phase_reg)
                            PP_NAME_LEN, PP_VALUE_LEN:
                            begin
                                kind = (pair_phase_reg == PP_NAME_LEN) ? KIND_NAME_LEN
                                                                       : KIND_VALUE_LEN;
                                if (len_left_reg == 2'd0) begin
                                    if (byte_in[LONG_LEN_BIT]) begin
                                        len_accum_next = {24'd0, byte_in[6:0]};
                                        len_left_next  = 2'd3;
                                    end
                                    else begin
                                        len_val  = {23'd0, byte_in};
                                        len_done = 1'b1;
                                    end
                                end
                                else begin
                                    len_accum_next = {len_accum_reg[22:0], byte_in};
                                    len_left_next  = len_left_reg - 2'd1;
                                    if (len_left_next == 2'd0) begin
                                        len_val  = len_accum_next;
                                        len_done = 1'b1;
                                    end
                                end
                                if (!len_done) begin
                                    dropped = (pair_phase_reg == PP_VALUE_LEN) && is_gv &&
                                              (name_len_reg == '0);
                                end
                                else if (pair_phase_reg == PP_NAME_LEN) begin
                                    plen            = len_val;
                                    name_len_next   = len_val;
                                    pair_phase_next = PP_VALUE_LEN;
                                    dropped         = is_gv && (len_val == '0);
                                end
                                else begin
                                    plen           = len_val;
                                    value_len_next = len_val;
                                    dropped        = is_gv && (name_len_reg == '0);
                                    need = {1'b0, name_len_reg} + {1'b0, len_val};
                                    if (need > {16'd0, remaining}) begin
                                        err_next = ERR_PAIR_OVERRUN;
                                    end
                                    else if (name_len_reg != '0) begin
                                        pair_phase_next = PP_NAME;
                                        pair_left_next  = name_len_reg;
                                    end
                                    else if (len_val != '0) begin
                                        pair_phase_next = PP_VALUE;
                                        pair_left_next  = len_val;
                                    end
                                    else begin
                                        pair_phase_next = PP_NAME_LEN;
                                    end
                                end
                            end
                            PP_NAME:
                            begin
                                kind = KIND_NAME;
                                left_dec = (pair_left_reg != '0) ? pair_left_reg - 31'd1
                                                                 : pair_left_reg;
                                pair_left_next = left_dec;
                                if (left_dec == '0) begin
                                    if (value_len_reg != '0) begin
                                        pair_phase_next = PP_VALUE;
                                        pair_left_next  = value_len_reg;
                                    end
                                    else begin
                                        pair_phase_next = PP_NAME_LEN;
                                    end
                                end
                            end
                            default:
                            begin
                                kind = KIND_VALUE;
                                dropped = is_gv && (name_len_reg == '0);
                                left_dec = (pair_left_reg != '0) ? pair_left_reg - 31'd1
                                                                 : pair_left_reg;
                                pair_left_next = left_dec;
                                if (left_dec == '0)
                                    pair_phase_next = PP_NAME_LEN;
                            end
                        endcase
                    end
                    else begin
                        kind = KIND_STREAM;
                    end

                    // End of content: an unfinished pair or length field is an overrun
                    if (err_next == ERR_NONE && content_cnt_next == content_len_reg) begin
                        if (is_pair && (pair_phase_next != PP_NAME_LEN ||
                                        len_left_next != 2'd0)) begin
                            err_next = ERR_PAIR_OVERRUN;
                        end
                        else if (pad_len_reg != 8'd0) begin
                            phase_next   = PH_PADDING;
                            pad_cnt_next = 8'd0;
                        end
                        else begin
                            phase_next = PH_HEADER;
                            last       = 1'b1;
                        end
                    end
                end
                PH_PADDING:
                begin
                    kind = KIND_PADDING;
                    pad_cnt_next = pad_cnt_reg + 8'd1;
                    if (pad_cnt_next == pad_len_reg) begin
                        phase_next = PH_HEADER;
                        last       = 1'b1;
                    end
                end
                default:
                begin
                    kind = KIND_HEADER;
                    case (hdr_idx_reg)
                        HDR_VERSION: rec_ver_next     = byte_in;
                        HDR_TYPE:    rec_type_next    = byte_in;
                        HDR_ID_HI:   rec_id_next      = {byte_in, rec_id_reg[7:0]};
                        HDR_ID_LO:   rec_id_next      = {rec_id_reg[15:8], byte_in};
                        HDR_LEN_HI:  content_len_next = {byte_in, content_len_reg[7:0]};
                        HDR_LEN_LO:  content_len_next = {content_len_reg[15:8], byte_in};
                        HDR_PAD:     pad_len_next     = byte_in;
                        default:     ;
                    endcase
                    if (hdr_idx_reg == HDR_LAST) begin
                        // Checks in priority order: type, version, id rule, body size
                        if (!(rec_type_reg inside {TYPE_BEGIN, TYPE_ABORT, TYPE_PARAMS,
                                                   TYPE_STDIN, TYPE_DATA, TYPE_GV, TYPE_GVR}))
                            hdr_err = ERR_TYPE;
                        else if (rec_ver_reg != expected_version)
                            hdr_err = ERR_VERSION;
                        else if ((rec_id_reg == 16'd0) != is_gv)
                            hdr_err = ERR_REQUEST_ID;
                        else if ((rec_type_reg == TYPE_BEGIN &&
                                  content_len_reg != 16'(HDR_LEN)) ||
                                 (rec_type_reg == TYPE_ABORT && content_len_reg != 16'd0))
                            hdr_err = ERR_BODY_LENGTH;
                        hdr_idx_next = 3'd0;
                        if (hdr_err != ERR_NONE) begin
                            err_next = hdr_err;
                        end
                        else begin
                            content_cnt_next = 16'd0;
                            pad_cnt_next     = 8'd0;
                            pair_phase_next  = PP_NAME_LEN;
                            len_accum_next   = '0;
                            len_left_next    = 2'd0;
                            pair_left_next   = '0;
                            if (content_len_reg != 16'd0) begin
                                phase_next = PH_CONTENT;
                            end
                            else if (pad_len_reg != 8'd0) begin
                                phase_next = PH_PADDING;
                            end
                            else begin
                                phase_next = PH_HEADER;
                                last       = 1'b1;
                            end
                        end
                    end
                    else begin
                        hdr_idx_next = hdr_idx_reg + 3'd1;
                    end
                end
            endcase
            if (err_next != ERR_NONE)
                last = 1'b0;
        end

        result.kind     = kind;
        result.data     = byte_in;
        result.rec_type = rec_type_next;
        result.req_id   = rec_id_next;
        result.pair_len = plen;
        result.role     = role_next;
        result.flags    = flags_next;
        result.dropped  = dropped;
        result.last     = last;
        result.err      = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= PH_HEADER;
            pair_phase_reg  <= PP_NAME_LEN;
            hdr_idx_reg     <= '0;
            rec_ver_reg     <= '0;
            rec_type_reg    <= '0;
            rec_id_reg      <= '0;
            content_len_reg <= '0;
            pad_len_reg     <= '0;
            content_cnt_reg <= '0;
            pad_cnt_reg     <= '0;
            len_accum_reg   <= '0;
            len_left_reg    <= '0;
            name_len_reg    <= '0;
            value_len_reg   <= '0;
            pair_left_reg   <= '0;
            role_reg        <= '0;
            flags_reg       <= '0;
            err_reg         <= ERR_NONE;
        end
        else if (advance) begin
            phase_reg       <= phase_next;
            pair_phase_reg  <= pair_phase_next;
            hdr_idx_reg     <= hdr_idx_next;
            rec_ver_reg     <= rec_ver_next;
            rec_type_reg    <= rec_type_next;
            rec_id_reg      <= rec_id_next;
            content_len_reg <= content_len_next;
            pad_len_reg     <= pad_len_next;
            content_cnt_reg <= content_cnt_next;
            pad_cnt_reg     <= pad_cnt_next;
            len_accum_reg   <= len_accum_next;
            len_left_reg    <= len_left_next;
            name_len_reg    <= name_len_next;
            value_len_reg   <= value_len_next;
            pair_left_reg   <= pair_left_next;
            role_reg        <= role_next;
            flags_reg       <= flags_next;
            err_reg         <= err_next;
        end
    end

endmodule

`default_nettype wire

### rtl/fcgi_out_reg.sv
// Result register of the deframer: holds one labeled word until taken.
// Depends on fcgi_pkg.
`default_nettype none

module fcgi_out_reg
    import fcgi_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load_valid,
    output logic              load_ready,
    input  wire fcgi_result_t load_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output fcgi_result_t      out_data
);

    logic         valid_reg;
    fcgi_result_t data_reg;

    assign load_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (load_ready) begin
            valid_reg <= load_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
            data_reg <= load_data;
    end

endmodule

`default_nettype wire

### rtl/fastcgi_record_deframer_core.sv
// Top level of the FastCGI record deframer: input register, parser, result register.
// Depends on fcgi_pkg, fcgi_parse and fcgi_out_reg.
`default_nettype none

// The deframer takes one byte of a FastCGI record stream per word and returns one
// labeled word for every byte, in order. Throughput is one byte per clock cycle while
// m_tready stays high; each byte passes the input register and then the result
// register; the parser between them updates all of its state as each byte advances.
// The header is checked on its eighth byte; the first error found (type, version,
// request-id rule, body length, or a name-value pair that runs past the content) is
// reported on that byte and then held on every later word until reset, with all
// later bytes labeled as discarded. expected_version is written through cfg_we and
// cfg_wdata and must only change while no bytes are in flight; it resets to 1.
module fastcgi_record_deframer_core
    import fcgi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [7:0]         cfg_wdata,   // expected_version
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,     // [7:0] in_byte
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,     // [7:0] data_byte, [15:8] record_type,
                                                 // [31:16] request_id, [62:32] pair_length,
                                                 // [78:63] role_value, [86:79] begin_flags,
                                                 // [89:87] error_code, [95:90] zero
    output logic [TUSER_W-1:0]      m_tuser,     // [3:0] byte_kind, [4] pair_dropped
    output logic                    m_tlast      // record_last
);

    logic         in_vld_reg;
    logic [7:0]   in_byte_reg;
    logic [7:0]   exp_ver_reg;
    logic         out_ready;
    logic         advance;
    fcgi_result_t parse_res;
    fcgi_result_t out_res;

    // Advance a byte from the input register whenever the result register has room
    assign advance  = in_vld_reg && out_ready;
    assign s_tready = !in_vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg  <= 1'b0;
            exp_ver_reg <= 8'd1;
        end
        else begin
            if (s_tready)
                in_vld_reg <= s_tvalid;
            if (cfg_we)
                exp_ver_reg <= cfg_wdata;
        end
    end

    // Hold the input byte until the parser consumes it
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    fcgi_parse u_parse (
        .clk              (clk),
        .rst_n            (rst_n),
        .expected_version (exp_ver_reg),
        .byte_in          (in_byte_reg),
        .advance          (advance),
        .result           (parse_res)
    );

    fcgi_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_vld_reg),
        .load_ready (out_ready),
        .load_data  (parse_res),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    // Pack the labeled word onto the master side
    assign m_tdata = {6'd0, out_res.err, out_res.flags, out_res.role, out_res.pair_len,
                      out_res.req_id, out_res.rec_type, out_res.data};
    assign m_tuser = {out_res.dropped, out_res.kind};
    assign m_tlast = out_res.last;

endmodule

`default_nettype wire

### rtl/fcgi_checker.sv
// Port-level checker for the deframer, bound to fastcgi_record_deframer_core.
// Depends on fcgi_pkg.
`default_nettype none

module fcgi_checker
    import fcgi_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic [TUSER_W-1:0] m_tuser,
    input wire logic               m_tlast
);

    logic       out_acc;
    logic [2:0] err_seen_reg;

    assign out_acc = m_tvalid && m_tready;

    // Track the error code of the last word taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            err_seen_reg <= '0;
        else if (out_acc)
            err_seen_reg <= m_tdata[89:87];
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("output word changed while stalled");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && err_seen_reg != 3'd0 |->
            m_tdata[89:87] == err_seen_reg && m_tuser[3:0] == KIND_DISCARD && !m_tlast)
        else $error("error code not held after it was reported");

    a_discard_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && m_tuser[3:0] == KIND_DISCARD |-> m_tdata[89:87] != 3'd0)
        else $error("discarded word without an error");

    a_last_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && m_tlast |-> m_tdata[89:87] == 3'd0)
        else $error("record end flagged on an error word");

    a_len_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && m_tuser[3:0] != KIND_NAME_LEN && m_tuser[3:0] != KIND_VALUE_LEN |->
            m_tdata[62:32] == 31'd0)
        else $error("pair length outside a length field");

endmodule

bind fastcgi_record_deframer_core fcgi_checker u_fcgi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
